>>> rtl/core/mbq_pkg.sv
// mbq_pkg: shared widths, register indexes and the coefficient bundle
// for the multichannel biquad filter; no dependencies
`default_nettype none

package mbq_pkg;

   // fixed field widths
   localparam int COEF_W      = 32;
   localparam int CH_W        = 4;
   localparam int CNT_W       = 5;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 32;

   // datapath widths
   localparam int STATE_W     = 48;   // delay words and y
   localparam int SPLIT_W     = 24;   // low half of a 48-bit multiplicand
   localparam int MUL_W       = 33;   // signed multiplier operand
   localparam int PROD_W      = 2 * MUL_W;
   localparam int ACC_W       = 82;   // exact coefficient times 48-bit value
   localparam int PB_FRAC     = 12;   // shift of the feedforward products

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   // register indexes
   typedef logic [CSR_IDX_W-1:0] csr_index_type;
   localparam csr_index_type REG_COEF_B0       = 3'd0;
   localparam csr_index_type REG_COEF_B1       = 3'd1;
   localparam csr_index_type REG_COEF_B2       = 3'd2;
   localparam csr_index_type REG_COEF_A1       = 3'd3;
   localparam csr_index_type REG_COEF_A2       = 3'd4;
   localparam csr_index_type REG_CHANNEL_COUNT = 3'd5;

   localparam logic [CNT_W-1:0] CHANNEL_COUNT_RESET = 5'd1;

   typedef struct packed {
      logic signed [COEF_W-1:0] b0;
      logic signed [COEF_W-1:0] b1;
      logic signed [COEF_W-1:0] b2;
      logic signed [COEF_W-1:0] a1;
      logic signed [COEF_W-1:0] a2;
   } coef_type;

endpackage

`default_nettype wire

>>> rtl/core/mbq_req_if.sv
// mbq_req_if: sample word channel into the filter (valid, ready, payload)
// depends on mbq_pkg
`default_nettype none

interface mbq_req_if import mbq_pkg::*; #(
   parameter int SAMPLE_WIDTH = 24
) ();

   logic                           valid;
   logic                           ready;
   logic [CH_W-1:0]                channel;
   logic signed [SAMPLE_WIDTH-1:0] sample_in;

   modport source (output valid, output channel, output sample_in, input ready);
   modport sink   (input valid, input channel, input sample_in, output ready);

endinterface

`default_nettype wire

>>> rtl/core/mbq_rsp_if.sv
// mbq_rsp_if: filtered word channel out of the filter (valid, ready, payload)
// depends on mbq_pkg
`default_nettype none

interface mbq_rsp_if import mbq_pkg::*; #(
   parameter int SAMPLE_WIDTH = 24
) ();

   logic                           valid;
   logic                           ready;
   logic [CH_W-1:0]                channel_out;
   logic signed [SAMPLE_WIDTH-1:0] sample_out;
   logic                           saturated;

   modport source (output valid, output channel_out, output sample_out, output saturated,
                   input ready);
   modport sink   (input valid, input channel_out, input sample_out, input saturated,
                   output ready);

endinterface

`default_nettype wire

>>> rtl/core/mbq_csr.sv
// mbq_csr: coefficient and channel count registers behind the write port
// depends on mbq_pkg
`default_nettype none

module mbq_csr import mbq_pkg::*; #(
   parameter int COEF_FRAC_BITS = 28
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output coef_type              coef,
   output logic [CNT_W-1:0]      chan_count
);

   coef_type         coef_ff, coef_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // write decode, unknown indexes are dropped
   always_comb begin
      coef_in  = coef_ff;
      count_in = count_ff;
      if (csr_we) begin
         case (csr_index)
            REG_COEF_B0:       coef_in.b0 = signed'(csr_wdata[COEF_W-1:0]);
            REG_COEF_B1:       coef_in.b1 = signed'(csr_wdata[COEF_W-1:0]);
            REG_COEF_B2:       coef_in.b2 = signed'(csr_wdata[COEF_W-1:0]);
            REG_COEF_A1:       coef_in.a1 = signed'(csr_wdata[COEF_W-1:0]);
            REG_COEF_A2:       coef_in.a2 = signed'(csr_wdata[COEF_W-1:0]);
            REG_CHANNEL_COUNT: count_in   = csr_wdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   // b0 resets to unity gain
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff.b0 <= COEF_W'(1) << COEF_FRAC_BITS;
         coef_ff.b1 <= '0;
         coef_ff.b2 <= '0;
         coef_ff.a1 <= '0;
         coef_ff.a2 <= '0;
         count_ff   <= CHANNEL_COUNT_RESET;
      end else begin
         coef_ff  <= coef_in;
         count_ff <= count_in;
      end
   end

   assign coef       = coef_ff;
   assign chan_count = count_ff;

endmodule

`default_nettype wire

>>> rtl/core/mbq_front.sv
// mbq_front: takes request words, drops those for inactive channels and
// pushes the rest into the work queue; depends on mbq_pkg, mbq_req_if
`default_nettype none

module mbq_front import mbq_pkg::*; #(
   parameter int MAX_CHANNELS = 16,
   parameter int SAMPLE_WIDTH = 24
) (
   mbq_req_if.sink                        req_if,
   input  logic [CNT_W-1:0]               chan_count,
   input  logic                           q_full,
   output logic                           q_push,
   output logic [CH_W+SAMPLE_WIDTH-1:0]   q_wdata
);

   logic ch_active;

   // channel must lie below both the programmed count and the build limit
   assign ch_active = (32'(req_if.channel) < 32'(chan_count)) &&
                      (32'(req_if.channel) < MAX_CHANNELS);

   // inactive words are taken and discarded
   assign req_if.ready = !q_full;
   assign q_push       = req_if.valid && !q_full && ch_active;
   assign q_wdata      = {req_if.channel, req_if.sample_in};

endmodule

`default_nettype wire

>>> rtl/core/mbq_queue.sv
// mbq_queue: short first-in first-out queue between front and back end
// depends on mbq_pkg
`default_nettype none

module mbq_queue import mbq_pkg::*; #(
   parameter int WIDTH = 28
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   input  logic             pop,
   output logic             full,
   output logic             empty,
   output logic [WIDTH-1:0] rdata
);

   localparam int CNT_QW = QUEUE_PTR_W + 1;

   logic [WIDTH-1:0]       store_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_QW-1:0]      count_ff, count_in;

   assign full  = (count_ff == CNT_QW'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign rdata = store_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                     wr_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                     rd_ptr_ff + QUEUE_PTR_W'(1);
      end
      count_in = count_ff + CNT_QW'(push) - CNT_QW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/mbq_back.sv
// mbq_back: per-word sequencer with one shared multiplier, the per-channel
// delay stores and the result register; depends on mbq_pkg, mbq_rsp_if
`default_nettype none

module mbq_back import mbq_pkg::*; #(
   parameter int MAX_CHANNELS   = 16,
   parameter int SAMPLE_WIDTH   = 24,
   parameter int COEF_FRAC_BITS = 28
) (
   input  logic                           clock,
   input  logic                           reset,
   input  coef_type                       coef,
   input  logic                           q_empty,
   input  logic [CH_W+SAMPLE_WIDTH-1:0]   q_data,
   output logic                           q_pop,
   mbq_rsp_if.source                      rsp_if
);

   localparam int IDX_W      = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int STATE_FRAC = COEF_FRAC_BITS - PB_FRAC;
   localparam int RND_W      = STATE_W + 1;

   localparam logic signed [ACC_W-1:0] HALF_PB = ACC_W'(1) << (PB_FRAC - 1);
   localparam logic signed [ACC_W-1:0] HALF_FB = ACC_W'(1) << (COEF_FRAC_BITS - 1);
   localparam logic signed [ACC_W-1:0] SAT_HI  = ACC_W'({1'b0, {(STATE_W-1){1'b1}}});
   localparam logic signed [ACC_W-1:0] SAT_LO  = -(ACC_W'(1) << (STATE_W - 1));
   localparam logic signed [RND_W-1:0] HALF_OUT = (RND_W'(1) << STATE_FRAC) >> 1;
   localparam logic signed [RND_W-1:0] SMAX =
      (RND_W'(1) << (SAMPLE_WIDTH - 1)) - RND_W'(1);
   localparam logic signed [RND_W-1:0] SMIN = -(RND_W'(1) << (SAMPLE_WIDTH - 1));

   typedef enum logic [8:0] {
      ST_IDLE = 9'b000000001,
      ST_B1   = 9'b000000010,
      ST_B2   = 9'b000000100,
      ST_A1L  = 9'b000001000,
      ST_A1H  = 9'b000010000,
      ST_A2L  = 9'b000100000,
      ST_A2H  = 9'b001000000,
      ST_A2F  = 9'b010000000,
      ST_WB   = 9'b100000000
   } back_state_type;

   // clamp an exact value to a signed 48-bit state word
   function automatic logic signed [STATE_W-1:0] sat_state(
      input logic signed [ACC_W-1:0] x
   );
      logic signed [STATE_W-1:0] r;
      if (x > SAT_HI) begin
         r = SAT_HI[STATE_W-1:0];
      end else if (x < SAT_LO) begin
         r = SAT_LO[STATE_W-1:0];
      end else begin
         r = x[STATE_W-1:0];
      end
      return r;
   endfunction

   back_state_type state_ff, state_in;

   // word under work
   logic [CH_W-1:0]                ch_ff, ch_in;
   logic signed [SAMPLE_WIDTH-1:0] u_ff, u_in;

   // delay stores, one valid bit per channel stands in for the zero reset
   logic signed [STATE_W-1:0] z1_mem [MAX_CHANNELS];
   logic signed [STATE_W-1:0] z2_mem [MAX_CHANNELS];
   logic [MAX_CHANNELS-1:0]   zvalid_ff, zvalid_in;
   logic signed [STATE_W-1:0] z1_rd_ff, z2_rd_ff;
   logic                      zv_rd_ff;

   // arithmetic registers
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [STATE_W-1:0] pb0_ff, pb0_in, pb1_ff, pb1_in, pb2_ff, pb2_in;
   logic signed [STATE_W-1:0] y_ff, y_in, pa1_ff, pa1_in, pa2_ff, pa2_in;
   logic signed [STATE_W-1:0] z1n_ff, z1n_in;
   logic signed [RND_W-1:0]   t1_ff, t1_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;

   // result register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [CH_W-1:0]                rsp_ch_ff, rsp_ch_in;
   logic signed [SAMPLE_WIDTH-1:0] rsp_sample_ff, rsp_sample_in;
   logic                           rsp_sat_ff, rsp_sat_in;

   // combinational helpers
   logic [CH_W-1:0]                head_ch;
   logic signed [SAMPLE_WIDTH-1:0] head_u;
   logic [IDX_W-1:0]               head_idx, wb_idx;
   logic                           take, out_free, wb_go;
   logic signed [STATE_W-1:0]      z1_cur, z2_cur, z2n;
   logic signed [MUL_W-1:0]        mul_a, mul_b, y_lo_op, y_hi_op;
   logic signed [ACC_W-1:0]        prod_ext, fb_sum;
   logic signed [STATE_W-1:0]      pb_rnd, fb_rnd;
   logic signed [RND_W-1:0]        y_rnd;

   assign head_ch  = q_data[CH_W+SAMPLE_WIDTH-1:SAMPLE_WIDTH];
   assign head_u   = signed'(q_data[SAMPLE_WIDTH-1:0]);
   assign head_idx = IDX_W'(head_ch);
   assign wb_idx   = IDX_W'(ch_ff);

   assign take     = (state_ff == ST_IDLE) && !q_empty;
   assign q_pop    = take;
   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign wb_go    = (state_ff == ST_WB) && out_free;

   assign z1_cur = zv_rd_ff ? z1_rd_ff : '0;
   assign z2_cur = zv_rd_ff ? z2_rd_ff : '0;

   // y split into an unsigned low half and a signed high half
   assign y_lo_op = signed'({{(MUL_W-SPLIT_W){1'b0}}, y_ff[SPLIT_W-1:0]});
   assign y_hi_op = MUL_W'(signed'(y_ff[STATE_W-1:SPLIT_W]));

   // shared multiplier operand select
   always_comb begin
      case (state_ff)
         ST_IDLE: begin mul_a = MUL_W'(coef.b0); mul_b = MUL_W'(head_u); end
         ST_B1:   begin mul_a = MUL_W'(coef.b1); mul_b = MUL_W'(u_ff);   end
         ST_B2:   begin mul_a = MUL_W'(coef.b2); mul_b = MUL_W'(u_ff);   end
         ST_A1L:  begin mul_a = MUL_W'(coef.a1); mul_b = y_lo_op;        end
         ST_A1H:  begin mul_a = MUL_W'(coef.a1); mul_b = y_hi_op;        end
         ST_A2L:  begin mul_a = MUL_W'(coef.a2); mul_b = y_lo_op;        end
         ST_A2H:  begin mul_a = MUL_W'(coef.a2); mul_b = y_hi_op;        end
         default: begin mul_a = '0;              mul_b = '0;             end
      endcase
      prod_in = mul_a * mul_b;
   end

   // rounding of the products
   always_comb begin
      prod_ext = ACC_W'(prod_ff);
      pb_rnd   = sat_state((prod_ext + HALF_PB) >>> PB_FRAC);
      fb_sum   = acc_ff + (prod_ext <<< SPLIT_W);
      fb_rnd   = sat_state(fb_sum >>> COEF_FRAC_BITS);
      z2n      = sat_state(ACC_W'(pb2_ff) - ACC_W'(pa2_ff));
      y_rnd    = (RND_W'(y_ff) + HALF_OUT) >>> STATE_FRAC;
   end

   // sequencer and datapath next values
   always_comb begin
      state_in = state_ff;
      ch_in    = ch_ff;
      u_in     = u_ff;
      pb0_in   = pb0_ff;
      pb1_in   = pb1_ff;
      pb2_in   = pb2_ff;
      y_in     = y_ff;
      t1_in    = t1_ff;
      acc_in   = acc_ff;
      pa1_in   = pa1_ff;
      pa2_in   = pa2_ff;
      z1n_in   = z1n_ff;
      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               ch_in    = head_ch;
               u_in     = head_u;
               state_in = ST_B1;
            end
         end
         ST_B1: begin
            pb0_in   = pb_rnd;
            state_in = ST_B2;
         end
         ST_B2: begin
            pb1_in   = pb_rnd;
            y_in     = sat_state(ACC_W'(pb0_ff) + ACC_W'(z1_cur));
            state_in = ST_A1L;
         end
         ST_A1L: begin
            pb2_in   = pb_rnd;
            t1_in    = RND_W'(pb1_ff) + RND_W'(z2_cur);
            state_in = ST_A1H;
         end
         ST_A1H: begin
            acc_in   = prod_ext + HALF_FB;
            state_in = ST_A2L;
         end
         ST_A2L: begin
            pa1_in   = fb_rnd;
            state_in = ST_A2H;
         end
         ST_A2H: begin
            acc_in   = prod_ext + HALF_FB;
            z1n_in   = sat_state(ACC_W'(t1_ff) - ACC_W'(pa1_ff));
            state_in = ST_A2F;
         end
         ST_A2F: begin
            pa2_in   = fb_rnd;
            state_in = ST_WB;
         end
         ST_WB: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // result register, output rounding and clip
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_ch_in     = rsp_ch_ff;
      rsp_sample_in = rsp_sample_ff;
      rsp_sat_in    = rsp_sat_ff;
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (wb_go) begin
         rsp_valid_in = 1'b1;
         rsp_ch_in    = ch_ff;
         if (y_rnd > SMAX) begin
            rsp_sample_in = SMAX[SAMPLE_WIDTH-1:0];
            rsp_sat_in    = 1'b1;
         end else if (y_rnd < SMIN) begin
            rsp_sample_in = SMIN[SAMPLE_WIDTH-1:0];
            rsp_sat_in    = 1'b1;
         end else begin
            rsp_sample_in = y_rnd[SAMPLE_WIDTH-1:0];
            rsp_sat_in    = 1'b0;
         end
      end
   end

   // a channel becomes valid at its first write-back
   always_comb begin
      zvalid_in = zvalid_ff;
      if (wb_go) begin
         zvalid_in[wb_idx] = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         zvalid_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         zvalid_ff    <= zvalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      prod_ff       <= prod_in;
      ch_ff         <= ch_in;
      u_ff          <= u_in;
      pb0_ff        <= pb0_in;
      pb1_ff        <= pb1_in;
      pb2_ff        <= pb2_in;
      y_ff          <= y_in;
      t1_ff         <= t1_in;
      acc_ff        <= acc_in;
      pa1_ff        <= pa1_in;
      pa2_ff        <= pa2_in;
      z1n_ff        <= z1n_in;
      rsp_ch_ff     <= rsp_ch_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_sat_ff    <= rsp_sat_in;
   end

   // delay stores: registered read on take, write on write-back
   always_ff @(posedge clock) begin
      if (take) begin
         z1_rd_ff <= z1_mem[head_idx];
         z2_rd_ff <= z2_mem[head_idx];
         zv_rd_ff <= zvalid_ff[head_idx];
      end
      if (wb_go) begin
         z1_mem[wb_idx] <= z1n_ff;
         z2_mem[wb_idx] <= z2n;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.channel_out = rsp_ch_ff;
   assign rsp_if.sample_out  = rsp_sample_ff;
   assign rsp_if.saturated   = rsp_sat_ff;

endmodule

`default_nettype wire

>>> rtl/core/multichannel_biquad_filter.sv
// multichannel_biquad_filter: top level, register file, front end, queue
// and back end; depends on mbq_pkg, mbq_req_if, mbq_rsp_if and the mbq_ modules
//
//   port     | dir | handshake       | word
//   ---------+-----+-----------------+-----------------------------------------
//   req_if   | in  | valid / ready   | channel, sample_in
//   rsp_if   | out | valid / ready   | channel_out, sample_out, saturated
//   csr_*    | in  | csr_we only     | csr_index, csr_wdata (no read-back)
//
// each active word passes through the idle/take state and eight sequencer
// steps in the back end, around the single 33x33 multiplier, which makes seven
// passes per word (three for b0..b2, two half-word passes each for a1 and a2)
// a new word is taken only in idle; rsp valid comes from the result register
// reset is synchronous; per-channel valid bits make every delay word read as
// zero until written, so no clearing pass follows reset
// a stalled rsp holds the back end at write-back; the two-word queue keeps
// req ready until it fills; words for inactive channels are taken and dropped
`default_nettype none

module multichannel_biquad_filter import mbq_pkg::*; #(
   parameter int MAX_CHANNELS   = 16,
   parameter int SAMPLE_WIDTH   = 24,
   parameter int COEF_FRAC_BITS = 28
) (
   input  logic                  clock,
   input  logic                  reset,
   mbq_req_if.sink               req_if,
   mbq_rsp_if.source             rsp_if,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int QW = CH_W + SAMPLE_WIDTH;

   coef_type         coef;
   logic [CNT_W-1:0] chan_count;
   logic             q_push, q_pop, q_full, q_empty;
   logic [QW-1:0]    q_wdata, q_rdata;

   // configuration registers
   mbq_csr #(
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .coef       (coef),
      .chan_count (chan_count)
   );

   // accept and classify
   mbq_front #(
      .MAX_CHANNELS (MAX_CHANNELS),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_front (
      .req_if     (req_if),
      .chan_count (chan_count),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_wdata    (q_wdata)
   );

   // work queue
   mbq_queue #(
      .WIDTH (QW)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .pop   (q_pop),
      .full  (q_full),
      .empty (q_empty),
      .rdata (q_rdata)
   );

   // filter arithmetic and result register
   mbq_back #(
      .MAX_CHANNELS   (MAX_CHANNELS),
      .SAMPLE_WIDTH   (SAMPLE_WIDTH),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .coef    (coef),
      .q_empty (q_empty),
      .q_data  (q_rdata),
      .q_pop   (q_pop),
      .rsp_if  (rsp_if)
   );

endmodule

`default_nettype wire

>>> rtl/core/mbq_checker.sv
// mbq_checker: port-level checks on the result channel of the filter,
// bound to multichannel_biquad_filter; no package dependencies
`default_nettype none

module mbq_checker #(
   parameter int SAMPLE_WIDTH = 24
) (
   input logic                    clock,
   input logic                    reset,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic [3:0]              rsp_channel,
   input logic [SAMPLE_WIDTH-1:0] rsp_sample,
   input logic                    rsp_saturated
);

   localparam logic [SAMPLE_WIDTH-1:0] SMAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic [SAMPLE_WIDTH-1:0] SMIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

   // no stale result survives reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // a clipped word sits on one of the two rails
   a_sat_rail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |-> (rsp_sample == SMAX) || (rsp_sample == SMIN))
      else $error("saturated flag without rail value");

   // stalled word stays offered
   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp word withdrawn while stalled");

   // stalled word keeps its payload
   a_hold_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(rsp_channel) && $stable(rsp_sample) && $stable(rsp_saturated))
      else $error("rsp word changed while stalled");

endmodule

bind multichannel_biquad_filter mbq_checker #(
   .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_mbq_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_if.valid),
   .rsp_ready     (rsp_if.ready),
   .rsp_channel   (rsp_if.channel_out),
   .rsp_sample    (rsp_if.sample_out),
   .rsp_saturated (rsp_if.saturated)
);

`default_nettype wire
